// File: rtl/goch_pkg.sv
// Shared types and constants for the gradient orientation cell histogram.
// Holds command codes, transaction structs, state enums and boundary directions.
package goch_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] pixel;
    logic [9:0] bin_index;
  } in_t;

  typedef struct packed {
    logic [20:0] bin_value;
    logic        frame_done;
  } out_t;

  localparam int          BIN_COUNT   = 9;
  localparam int          QUEUE_DEPTH = 2;
  localparam int          VAL_W       = 21;
  localparam logic [20:0] BIN_MAX     = 21'h1FFFFF;

  localparam logic REG_CELLS_ACROSS = 1'b0;
  localparam logic REG_CELLS_DOWN   = 1'b1;

  typedef enum logic [2:0] {
    F_IDLE, F_PIX, F_PIX2, F_WAIT, F_RDATA, F_CLRW
  } front_e;

  typedef enum logic [2:0] {
    B_CLEAR, B_IDLE, B_SQ, B_CALC, B_READ, B_WRITE
  } back_e;

  typedef struct packed {
    logic rd_req;
    logic clr_req;
  } bk_req_t;

  function automatic logic signed [31:0] dir_c(input logic lower, input logic [1:0] k);
    logic signed [31:0] v;
    v = '0;
    unique case ({lower, k})
      3'd0: v = 32'sd822533959;
      3'd1: v = 32'sd186453311;
      3'd2: v = -32'sd536870912;
      3'd3: v = -32'sd1008987269;
      3'd4: v = 32'sd1008987269;
      3'd5: v = 32'sd536870912;
      3'd6: v = -32'sd186453311;
      3'd7: v = -32'sd822533959;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] dir_s(input logic lower, input logic [1:0] k);
    logic signed [31:0] v;
    v = '0;
    unique case ({lower, k})
      3'd0: v = 32'sd690187940;
      3'd1: v = 32'sd1057429273;
      3'd2: v = 32'sd929887697;
      3'd3: v = 32'sd367241333;
      3'd4: v = 32'sd367241333;
      3'd5: v = 32'sd929887697;
      3'd6: v = 32'sd1057429273;
      3'd7: v = 32'sd690187940;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/gradient_orientation_cell_histogram_top.sv
// Top level: configuration registers, front end, operation queue, back end; uses goch_pkg.
// Each push makes at most two histogram updates, each with a 13-step square root.
// One command in flight; busy_o high until its strobe.
// After reset a clearing sweep zeroes the histograms.
// Results are shown for one cycle on result_valid_o; the receiver cannot stall.
module gradient_orientation_cell_histogram_top #(
  parameter int CELL_PX     = 16,
  parameter int MAX_CELLS_X = 8,
  parameter int MAX_CELLS_Y = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  goch_pkg::in_t  item_i,
  output logic           result_valid_o,
  output goch_pkg::out_t result_o,
  input  logic           cfg_we_i,
  input  logic [0:0]     cfg_idx_i,
  input  logic [3:0]     cfg_data_i
);
  localparam int HIST_DEPTH = MAX_CELLS_X * MAX_CELLS_Y * goch_pkg::BIN_COUNT;
  localparam int HAW        = $clog2(HIST_DEPTH);
  localparam int OPW        = HAW + 18;

  logic [3:0]        across_q, down_q;
  logic              front_idle, bk_idle, fifo_empty, fifo_full;
  logic              op_push, op_pop;
  logic [OPW-1:0]    op_wdata, op_rdata;
  goch_pkg::bk_req_t bk_req;
  logic [HAW-1:0]    rd_addr;
  logic [20:0]       rd_data;

  assign busy_o = !front_idle || !(bk_idle && fifo_empty);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      across_q <= 4'd1;
      down_q   <= 4'd1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == goch_pkg::REG_CELLS_ACROSS) begin
        across_q <= cfg_data_i;
      end else begin
        down_q <= cfg_data_i;
      end
    end
  end

  goch_front #(
    .CELL_PX    (CELL_PX),
    .MAX_CELLS_X(MAX_CELLS_X),
    .MAX_CELLS_Y(MAX_CELLS_Y),
    .HIST_DEPTH (HIST_DEPTH),
    .HAW        (HAW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i && !busy_o),
    .item_i        (item_i),
    .cells_across_i(across_q),
    .cells_down_i  (down_q),
    .idle_o        (front_idle),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .op_push_o     (op_push),
    .op_data_o     (op_wdata),
    .op_full_i     (fifo_full),
    .bk_idle_i     (bk_idle && fifo_empty),
    .bk_req_o      (bk_req),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data)
  );

  goch_fifo #(
    .WIDTH(OPW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (op_push),
    .data_i (op_wdata),
    .pop_i  (op_pop),
    .data_o (op_rdata),
    .empty_o(fifo_empty),
    .full_o (fifo_full)
  );

  goch_back #(
    .HIST_DEPTH(HIST_DEPTH),
    .HAW       (HAW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_valid_i(!fifo_empty),
    .op_data_i (op_rdata),
    .op_pop_o  (op_pop),
    .req_i     (bk_req),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .idle_o    (bk_idle)
  );
endmodule

// File: rtl/goch_fifo.sv
// Short queue of accumulate operations between front and back.
// Depends on goch_pkg for its depth.
module goch_fifo #(
  parameter int WIDTH = 30
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);
  localparam int PW = (goch_pkg::QUEUE_DEPTH > 1) ? $clog2(goch_pkg::QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(goch_pkg::QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [goch_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == NW'(goch_pkg::QUEUE_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(goch_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(goch_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule

// File: rtl/goch_back.sv
// Back end: magnitude square root, orientation bin and histogram update.
// Owns the histogram memory, its clearing sweep and the read port; uses goch_pkg.
module goch_back #(
  parameter int HIST_DEPTH = 576,
  parameter int HAW        = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  op_valid_i,
  input  logic [HAW+17:0]       op_data_i,
  output logic                  op_pop_o,
  input  goch_pkg::bk_req_t     req_i,
  input  logic [HAW-1:0]        rd_addr_i,
  output logic [20:0]           rd_data_o,
  output logic                  idle_o
);
  goch_pkg::back_e state_q, state_d;

  logic [20:0]        hist_mem [HIST_DEPTH];
  logic [20:0]        rdata_q;
  logic               we;
  logic [HAW-1:0]     wa, ra;
  logic [20:0]        wd;

  logic [HAW-1:0]     clr_q, clr_d;
  logic [HAW-1:0]     base_q, base_d;
  logic signed [8:0]  gx_q, gx_d, gy_q, gy_d;
  logic signed [9:0]  x_q, x_d, y_q, y_d;
  logic               lower_q, lower_d;
  logic [3:0]         bin_q, bin_d;
  logic [3:0]         it_q, it_d;
  logic [24:0]        rem_q, rem_d;
  logic [25:0]        root_q, root_d, bit_q, bit_d;
  logic [13:0]        mag_q, mag_d;

  logic signed [17:0] sx, sy;
  logic [24:0]        nsq;
  logic [25:0]        trial;
  logic signed [41:0] p0, p1;
  logic signed [42:0] dif;
  logic [21:0]        sum;
  logic               upper;

  assign idle_o    = (state_q == goch_pkg::B_IDLE);
  assign rd_data_o = rdata_q;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    base_d   = base_q;
    gx_d     = gx_q;
    gy_d     = gy_q;
    x_d      = x_q;
    y_d      = y_q;
    lower_d  = lower_q;
    bin_d    = bin_q;
    it_d     = it_q;
    rem_d    = rem_q;
    root_d   = root_q;
    bit_d    = bit_q;
    mag_d    = mag_q;
    op_pop_o = 1'b0;
    we       = 1'b0;
    wa       = clr_q;
    wd       = '0;
    ra       = rd_addr_i;
    sx       = gx_q * gx_q;
    sy       = gy_q * gy_q;
    nsq      = {25'(sx + sy)} << 8;
    upper    = (gy_q > 0) || (gy_q == 0 && gx_q >= 0);
    trial    = root_q + bit_q;
    p0       = goch_pkg::dir_c(lower_q, it_q[1:0]) * y_q;
    p1       = goch_pkg::dir_s(lower_q, it_q[1:0]) * x_q;
    dif      = 43'(p0) - 43'(p1);
    sum      = {1'b0, rdata_q} + 22'(mag_q);
    unique case (state_q)
      goch_pkg::B_CLEAR: begin
        we    = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == HAW'(HIST_DEPTH - 1)) begin
          state_d = goch_pkg::B_IDLE;
        end
      end
      goch_pkg::B_IDLE: begin
        if (req_i.clr_req) begin
          clr_d   = '0;
          state_d = goch_pkg::B_CLEAR;
        end else if (op_valid_i) begin
          op_pop_o = 1'b1;
          base_d   = op_data_i[HAW+17:18];
          gx_d     = op_data_i[17:9];
          gy_d     = op_data_i[8:0];
          state_d  = goch_pkg::B_SQ;
        end
      end
      goch_pkg::B_SQ: begin
        rem_d   = nsq;
        root_d  = '0;
        bit_d   = 26'd1 << 24;
        it_d    = '0;
        lower_d = !upper;
        x_d     = upper ? 10'(gx_q) : -10'(gx_q);
        y_d     = upper ? 10'(gy_q) : -10'(gy_q);
        bin_d   = upper ? 4'd0 : 4'd4;
        state_d = goch_pkg::B_CALC;
      end
      goch_pkg::B_CALC: begin
        if ({1'b0, rem_q} >= trial) begin
          rem_d  = rem_q - trial[24:0];
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (it_q < 4'd4 && !dif[42]) begin
          bin_d = bin_q + 1'b1;
        end
        it_d = it_q + 1'b1;
        if (it_q == 4'd12) begin
          state_d = goch_pkg::B_READ;
        end
      end
      goch_pkg::B_READ: begin
        mag_d   = root_q[13:0] + 14'({1'b0, rem_q} > root_q);
        base_d  = base_q + HAW'(bin_q);
        ra      = base_q + HAW'(bin_q);
        state_d = goch_pkg::B_WRITE;
      end
      goch_pkg::B_WRITE: begin
        we      = 1'b1;
        wa      = base_q;
        wd      = (sum > {1'b0, goch_pkg::BIN_MAX}) ? goch_pkg::BIN_MAX : sum[20:0];
        state_d = goch_pkg::B_IDLE;
      end
      default: state_d = goch_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= goch_pkg::B_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    gx_q    <= gx_d;
    gy_q    <= gy_d;
    x_q     <= x_d;
    y_q     <= y_d;
    lower_q <= lower_d;
    bin_q   <= bin_d;
    it_q    <= it_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    bit_q   <= bit_d;
    mag_q   <= mag_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      hist_mem[wa] <= wd;
    end
    rdata_q <= hist_mem[ra];
  end
endmodule

// File: rtl/goch_front.sv
// Front end: command decode, line buffers, gradients and cell addressing.
// Feeds accumulate operations to the queue and drives results; uses goch_pkg.
module goch_front #(
  parameter int CELL_PX     = 16,
  parameter int MAX_CELLS_X = 8,
  parameter int MAX_CELLS_Y = 8,
  parameter int HIST_DEPTH  = 576,
  parameter int HAW         = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  goch_pkg::in_t      item_i,
  input  logic [3:0]         cells_across_i,
  input  logic [3:0]         cells_down_i,
  output logic               idle_o,
  output logic               result_valid_o,
  output goch_pkg::out_t     result_o,
  output logic               op_push_o,
  output logic [HAW+17:0]    op_data_o,
  input  logic               op_full_i,
  input  logic               bk_idle_i,
  output goch_pkg::bk_req_t  bk_req_o,
  output logic [HAW-1:0]     rd_addr_o,
  input  logic [20:0]        rd_data_i
);
  localparam int LINE_DEPTH = MAX_CELLS_X * CELL_PX;
  localparam int LW = $clog2(LINE_DEPTH);
  localparam int RW = $clog2(MAX_CELLS_Y * CELL_PX);
  localparam int SW = $clog2(CELL_PX);
  localparam int XW = $clog2(MAX_CELLS_X + 1);
  localparam int YW = $clog2(MAX_CELLS_Y + 1);
  localparam int CW = XW + YW;

  goch_pkg::front_e state_q, state_d;
  goch_pkg::in_t    cmd_q, cmd_d;

  logic [7:0]      la_mem [LINE_DEPTH];
  logic [7:0]      lt_mem [LINE_DEPTH];
  logic [7:0]      la0_q, la1_q, lt_q;
  logic [LW:0]     fill_q, fill_d;
  logic            mem_we;
  logic [LW-1:0]   c_rd1;

  logic [LW-1:0]   c_q, c_d;
  logic [SW-1:0]   csub_q, csub_d;
  logic [XW-1:0]   ccell_q, ccell_d;
  logic [RW-1:0]   r_q, r_d;
  logic [SW-1:0]   rsub_q, rsub_d;
  logic [YW-1:0]   rcell_q, rcell_d;
  logic [7:0]      rp0_q, rp0_d, rp1_q, rp1_d, rp2_q, rp2_d;
  logic            done_q, done_d;
  logic            op1_vld_q, op1_vld_d;
  logic [HAW+17:0] op1_q, op1_d;
  logic            res_vld_d;
  goch_pkg::out_t  res_d, res_q;
  logic            res_vld_q;

  logic [XW-1:0]   ca, cx0, cx1;
  logic [YW-1:0]   cd, cy0;
  logic [LW:0]     w;
  logic [RW:0]     h;
  logic            last_col, last_row;
  logic [7:0]      la0_v, la1_v, lt_v, up, left2;
  logic signed [8:0] gx0, gy0, gx1;
  logic [CW-1:0]   cell0, cell1;
  logic [HAW-1:0]  base0, base1;
  logic            ok0, ok1;

  assign idle_o         = (state_q == goch_pkg::F_IDLE);
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;
  assign rd_addr_o      = HAW'(cmd_q.bin_index);
  assign c_rd1          = (c_q == LW'(LINE_DEPTH - 1)) ? '0 : c_q + 1'b1;

  always_comb begin
    if (cells_across_i == '0) begin
      ca = XW'(1);
    end else if (32'(cells_across_i) > MAX_CELLS_X) begin
      ca = XW'(MAX_CELLS_X);
    end else begin
      ca = XW'(cells_across_i);
    end
    if (cells_down_i == '0) begin
      cd = YW'(1);
    end else if (32'(cells_down_i) > MAX_CELLS_Y) begin
      cd = YW'(MAX_CELLS_Y);
    end else begin
      cd = YW'(cells_down_i);
    end
    w        = (LW+1)'(32'(ca) * CELL_PX);
    h        = (RW+1)'(32'(cd) * CELL_PX);
    last_col = ({1'b0, c_q} + 1'b1) >= w;
    last_row = ({1'b0, r_q} + 1'b1) >= h;
    la0_v    = ({1'b0, c_q} < fill_q) ? la0_q : 8'd0;
    la1_v    = ({1'b0, c_rd1} < fill_q) ? la1_q : 8'd0;
    lt_v     = ({1'b0, c_q} < fill_q) ? lt_q : 8'd0;
    up       = (r_q == RW'(1)) ? cmd_q.pixel : lt_v;
    left2    = (c_q == LW'(1)) ? cmd_q.pixel : rp2_q;
    gy0      = $signed({1'b0, cmd_q.pixel}) - $signed({1'b0, up});
    gx0      = (c_q == '0 || last_col) ? 9'sd0 : $signed({1'b0, la1_v}) - $signed({1'b0, rp0_q});
    gx1      = $signed({1'b0, cmd_q.pixel}) - $signed({1'b0, left2});
    cy0      = (rsub_q == '0) ? rcell_q - 1'b1 : rcell_q;
    cx0      = ccell_q;
    cx1      = (csub_q == '0) ? ccell_q - 1'b1 : ccell_q;
    ok0      = (r_q != '0) && (cy0 < cd) && (cx0 < ca);
    ok1      = last_row && (c_q != '0) && (rcell_q < cd) && (cx1 < ca);
    cell0    = CW'(32'(cy0) * 32'(ca) + 32'(cx0));
    cell1    = CW'(32'(rcell_q) * 32'(ca) + 32'(cx1));
    base0    = HAW'(32'(cell0) * goch_pkg::BIN_COUNT);
    base1    = HAW'(32'(cell1) * goch_pkg::BIN_COUNT);
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    c_d       = c_q;
    csub_d    = csub_q;
    ccell_d   = ccell_q;
    r_d       = r_q;
    rsub_d    = rsub_q;
    rcell_d   = rcell_q;
    rp0_d     = rp0_q;
    rp1_d     = rp1_q;
    rp2_d     = rp2_q;
    done_d    = done_q;
    op1_vld_d = op1_vld_q;
    op1_d     = op1_q;
    fill_d    = fill_q;
    mem_we    = 1'b0;
    op_push_o = 1'b0;
    op_data_o = {base0, gx0, gy0};
    bk_req_o  = '0;
    res_vld_d = 1'b0;
    res_d     = res_q;
    unique case (state_q)
      goch_pkg::F_IDLE: begin
        if (start_i) begin
          cmd_d   = item_i;
          state_d = goch_pkg::F_WAIT;
          if (item_i.command == goch_pkg::CMD_PUSH && !done_q) begin
            state_d = goch_pkg::F_PIX;
          end else if (item_i.command == goch_pkg::CMD_CLEAR) begin
            c_d     = '0;
            csub_d  = '0;
            ccell_d = '0;
            r_d     = '0;
            rsub_d  = '0;
            rcell_d = '0;
            rp0_d   = '0;
            rp1_d   = '0;
            rp2_d   = '0;
            done_d  = 1'b0;
          end
        end
      end
      goch_pkg::F_PIX: begin
        op_push_o        = ok0;
        op1_vld_d        = ok1;
        op1_d            = {base1, gx1, 9'sd0};
        mem_we           = 1'b1;
        if ({1'b0, c_q} >= fill_q) begin
          fill_d = {1'b0, c_q} + 1'b1;
        end
        rp0_d            = la0_v;
        rp2_d            = rp1_q;
        rp1_d            = cmd_q.pixel;
        if (last_col) begin
          c_d     = '0;
          csub_d  = '0;
          ccell_d = '0;
          if (last_row) begin
            done_d = 1'b1;
          end else begin
            r_d = r_q + 1'b1;
            if (rsub_q == SW'(CELL_PX - 1)) begin
              rsub_d  = '0;
              rcell_d = rcell_q + 1'b1;
            end else begin
              rsub_d = rsub_q + 1'b1;
            end
          end
        end else begin
          c_d = c_q + 1'b1;
          if (csub_q == SW'(CELL_PX - 1)) begin
            csub_d  = '0;
            ccell_d = ccell_q + 1'b1;
          end else begin
            csub_d = csub_q + 1'b1;
          end
        end
        state_d = goch_pkg::F_PIX2;
      end
      goch_pkg::F_PIX2: begin
        op_data_o = op1_q;
        if (!op1_vld_q) begin
          state_d = goch_pkg::F_WAIT;
        end else if (!op_full_i) begin
          op_push_o = 1'b1;
          state_d   = goch_pkg::F_WAIT;
        end
      end
      goch_pkg::F_WAIT: begin
        if (bk_idle_i) begin
          if (cmd_q.command == goch_pkg::CMD_READ) begin
            bk_req_o.rd_req = 1'b1;
            state_d         = goch_pkg::F_RDATA;
          end else if (cmd_q.command == goch_pkg::CMD_CLEAR) begin
            bk_req_o.clr_req = 1'b1;
            state_d          = goch_pkg::F_CLRW;
          end else begin
            res_vld_d        = 1'b1;
            res_d.bin_value  = '0;
            res_d.frame_done = done_q;
            state_d          = goch_pkg::F_IDLE;
          end
        end
      end
      goch_pkg::F_RDATA: begin
        res_vld_d        = 1'b1;
        res_d.bin_value  = (32'(cmd_q.bin_index) < HIST_DEPTH) ? rd_data_i : '0;
        res_d.frame_done = done_q;
        state_d          = goch_pkg::F_IDLE;
      end
      goch_pkg::F_CLRW: begin
        if (bk_idle_i) begin
          res_vld_d        = 1'b1;
          res_d.bin_value  = '0;
          res_d.frame_done = done_q;
          state_d          = goch_pkg::F_IDLE;
        end
      end
      default: state_d = goch_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= goch_pkg::F_IDLE;
      c_q       <= '0;
      csub_q    <= '0;
      ccell_q   <= '0;
      r_q       <= '0;
      rsub_q    <= '0;
      rcell_q   <= '0;
      rp0_q     <= '0;
      rp1_q     <= '0;
      rp2_q     <= '0;
      done_q    <= 1'b0;
      op1_vld_q <= 1'b0;
      fill_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      c_q       <= c_d;
      csub_q    <= csub_d;
      ccell_q   <= ccell_d;
      r_q       <= r_d;
      rsub_q    <= rsub_d;
      rcell_q   <= rcell_d;
      rp0_q     <= rp0_d;
      rp1_q     <= rp1_d;
      rp2_q     <= rp2_d;
      done_q    <= done_d;
      op1_vld_q <= op1_vld_d;
      fill_q    <= fill_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    op1_q <= op1_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      la_mem[c_q] <= cmd_q.pixel;
      lt_mem[c_q] <= la0_v;
    end
    la0_q <= la_mem[c_q];
    la1_q <= la_mem[c_rd1];
    lt_q  <= lt_mem[c_q];
  end
endmodule

// File: bench/tb.sv
// Self-checking bench for gradient_orientation_cell_histogram_top.
// Depends on goch_pkg; predicts every transaction's result from its own model of the block.
module tb;

  localparam int CELL      = 16;
  localparam int CELLS_MAX = 8;
  localparam int LINE_LEN  = CELLS_MAX * CELL;
  localparam int BINS_ALL  = CELLS_MAX * CELLS_MAX * goch_pkg::BIN_COUNT;
  localparam int ITEM_GOAL = 1400;
  localparam int STALL_MAX = 6000;

  localparam longint UP_C[4] = '{822533959, 186453311, -536870912, -1008987269};
  localparam longint UP_S[4] = '{690187940, 1057429273, 929887697, 367241333};
  localparam longint LO_C[4] = '{1008987269, 536870912, -186453311, -822533959};
  localparam longint LO_S[4] = '{367241333, 929887697, 1057429273, 690187940};

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start_i = 1'b0;
  logic           busy_o;
  goch_pkg::in_t  item_i = '0;
  logic           result_valid_o;
  goch_pkg::out_t result_o;
  logic           cfg_we_i = 1'b0;
  logic [0:0]     cfg_idx_i = '0;
  logic [3:0]     cfg_data_i = '0;

  gradient_orientation_cell_histogram_top u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .item_i, .result_valid_o, .result_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  // model state
  logic [3:0]  m_across, m_down;
  logic [7:0]  m_above [LINE_LEN];
  logic [7:0]  m_above2 [LINE_LEN];
  logic [20:0] m_hist [BINS_ALL];
  int unsigned m_row, m_col;
  logic [7:0]  m_recent [4];
  logic        m_done;

  goch_pkg::in_t  pending_items [$];
  goch_pkg::out_t expected_results [$];
  int   mismatches = 0;
  int   items_queued = 0;
  int   items_sent = 0;
  int   results_seen = 0;
  int   phases = 0;
  int   stall_cycles = 0;
  int   gap_left = 0;

  function automatic int unsigned clamp_cells(logic [3:0] v);
    if (v == 0) return 1;
    if (v > CELLS_MAX) return CELLS_MAX;
    return v;
  endfunction

  function automatic int unsigned int_sqrt(int unsigned n);
    int unsigned root, bitv;
    root = 0;
    bitv = 32'h4000_0000;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic int unsigned angle_bin(int gx, int gy);
    longint x, y;
    int unsigned b;
    bit lower;
    x = gx;
    y = gy;
    lower = !(y > 0 || (y == 0 && x >= 0));
    if (lower) begin
      x = -x;
      y = -y;
    end
    b = lower ? 4 : 0;
    for (int k = 0; k < 4; k++) begin
      if (lower ? (LO_C[k] * y - LO_S[k] * x >= 0) : (UP_C[k] * y - UP_S[k] * x >= 0))
        b++;
    end
    return b;
  endfunction

  function automatic void add_gradient(int unsigned r, int unsigned c, int gx, int gy,
                                       int unsigned ca, int unsigned cd);
    int unsigned n, m, idx, total;
    n = (gx * gx + gy * gy) * 256;
    m = int_sqrt(n);
    if (n - m * m > m) m++;
    if (c / CELL >= ca || r / CELL >= cd) return;
    idx = ((r / CELL) * ca + c / CELL) * goch_pkg::BIN_COUNT + angle_bin(gx, gy);
    if (idx >= BINS_ALL) return;
    total = m_hist[idx] + m;
    m_hist[idx] = (total > goch_pkg::BIN_MAX) ? goch_pkg::BIN_MAX : total[20:0];
  endfunction

  function automatic void clear_model();
    foreach (m_hist[i]) m_hist[i] = '0;
    foreach (m_recent[i]) m_recent[i] = '0;
    m_row = 0;
    m_col = 0;
    m_done = 1'b0;
  endfunction

  function automatic goch_pkg::out_t predict_histogram(goch_pkg::in_t it);
    goch_pkg::out_t o;
    int unsigned ca, cd, w, h, r, c;
    bit last_col, last_row;
    int px, up, gx, gy, left2;
    o = '0;
    px = it.pixel;
    if (it.command == goch_pkg::CMD_PUSH && !m_done) begin
      ca = clamp_cells(m_across);
      cd = clamp_cells(m_down);
      w = ca * CELL;
      h = cd * CELL;
      r = m_row;
      c = m_col;
      last_col = (c + 1 >= w);
      last_row = (r + 1 >= h);
      if (r >= 1) begin
        up = (r == 1) ? px : int'(m_above2[c]);
        gy = px - up;
        gx = (c == 0 || last_col) ? 0 : int'(m_above[c + 1]) - int'(m_recent[0]);
        add_gradient(r - 1, c, gx, gy, ca, cd);
      end
      if (last_row && c >= 1) begin
        left2 = (c == 1) ? px : int'(m_recent[2]);
        add_gradient(r, c - 1, px - left2, 0, ca, cd);
      end
      m_recent[0] = m_above[c];
      m_above2[c] = m_above[c];
      m_above[c] = it.pixel;
      m_recent[2] = m_recent[1];
      m_recent[1] = it.pixel;
      if (last_col) begin
        m_col = 0;
        if (last_row) m_done = 1'b1;
        else m_row = r + 1;
      end else begin
        m_col = c + 1;
      end
    end else if (it.command == goch_pkg::CMD_READ) begin
      if (it.bin_index < BINS_ALL) o.bin_value = m_hist[it.bin_index];
    end else if (it.command == goch_pkg::CMD_CLEAR) begin
      clear_model();
    end
    o.frame_done = m_done;
    return o;
  endfunction

  task automatic queue_item(goch_pkg::cmd_e cmd, logic [7:0] px, logic [9:0] bi);
    goch_pkg::in_t it;
    it.command = cmd;
    it.pixel = px;
    it.bin_index = bi;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || start_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cells(logic [3:0] across, logic [3:0] down);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= goch_pkg::REG_CELLS_ACROSS;
    cfg_data_i <= across;
    m_across = across;
    @(posedge clk_i);
    cfg_idx_i <= goch_pkg::REG_CELLS_DOWN;
    cfg_data_i <= down;
    m_down = down;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    phases++;
  endtask

  function automatic logic [7:0] frame_pixel(int mode, int r, int c, int a, int b);
    case (mode)
      0: return $urandom_range(0, 255);
      1: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      2: return 8'(r * a + c * b);
      default: return 8'(a);
    endcase
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(posedge clk_i) begin
    bit fire;
    fire = start_i && !busy_o;
    if (fire) begin
      expected_results.push_back(predict_histogram(item_i));
      items_sent++;
      gap_left = pick_gap();
    end
    if (fire || !start_i) begin
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (pending_items.size() != 0) begin
        start_i <= 1'b1;
        item_i <= pending_items.pop_front();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    goch_pkg::out_t want;
    if (result_valid_o) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result_o);
      end else begin
        want = expected_results.pop_front();
        if (result_o.bin_value !== want.bin_value ||
            result_o.frame_done !== want.frame_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected bin_value=%0d frame_done=%0b, got %0d %0b",
                     want.bin_value, want.frame_done, result_o.bin_value,
                     result_o.frame_done);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || !rst_ni) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_MAX) begin
      $display("watchdog expired after %0d idle cycles", STALL_MAX);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int ca, cd, w, h, mode, a, b, limit, n;
    logic [3:0] raw_a, raw_d;
    m_across = 4'd1;
    m_down = 4'd1;
    foreach (m_above[i]) m_above[i] = '0;
    foreach (m_above2[i]) m_above2[i] = '0;
    clear_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: read extremes, unused command, a clear, pushes at pixel extremes
    queue_item(goch_pkg::CMD_READ, 8'h00, 10'd0);
    queue_item(goch_pkg::CMD_READ, 8'hFF, 10'd575);
    queue_item(goch_pkg::CMD_READ, 8'h00, 10'd576);
    queue_item(goch_pkg::CMD_READ, 8'hFF, 10'd1023);
    queue_item(goch_pkg::CMD_NONE, 8'hFF, 10'h3FF);
    queue_item(goch_pkg::CMD_CLEAR, 8'h00, 10'd0);
    for (int i = 0; i < 6; i++)
      queue_item(goch_pkg::CMD_PUSH, (i % 2) ? 8'hFF : 8'h00, 10'd0);
    wait_drained();
    write_cells(4'd15, 4'd15);
    for (int i = 0; i < 10; i++)
      queue_item(goch_pkg::CMD_PUSH, (i % 3) ? 8'h00 : 8'hFF, 10'h3FF);
    queue_item(goch_pkg::CMD_READ, 8'h00, 10'd0);
    wait_drained();
    // shrink the window mid-row
    write_cells(4'd0, 4'd0);
    for (int i = 0; i < 4; i++) queue_item(goch_pkg::CMD_PUSH, 8'(i * 60), 10'd0);
    for (int i = 0; i < 3; i++) queue_item(goch_pkg::CMD_READ, 8'h00, 10'(i));
    wait_drained();

    while (items_queued < ITEM_GOAL) begin
      n = $urandom_range(0, 99);
      raw_a = (n < 70) ? 4'd1 : (n < 85) ? 4'd2 : (n < 90) ? 4'd0 : 4'($urandom_range(3, 15));
      n = $urandom_range(0, 99);
      raw_d = (n < 75) ? 4'd1 : (n < 88) ? 4'd2 : (n < 93) ? 4'd0 : 4'($urandom_range(3, 15));
      write_cells(raw_a, raw_d);
      ca = clamp_cells(raw_a);
      cd = clamp_cells(raw_d);
      w = ca * CELL;
      h = cd * CELL;
      limit = (ca * cd > 2) ? $urandom_range(150, 300) : w * h;
      if ($urandom_range(0, 7) == 0) limit = $urandom_range(1, limit);
      if (limit > ITEM_GOAL - items_queued) limit = ITEM_GOAL - items_queued;
      mode = $urandom_range(0, 3);
      a = $urandom_range(0, 255);
      b = $urandom_range(0, 255);
      queue_item(goch_pkg::CMD_CLEAR, 8'($urandom), 10'($urandom));
      for (int i = 0; i < limit; i++) begin
        queue_item(goch_pkg::CMD_PUSH, frame_pixel(mode, i / w, i % w, a, b), 10'($urandom));
        n = $urandom_range(0, 99);
        if (n < 4)
          queue_item(goch_pkg::CMD_READ, 8'($urandom),
                     10'($urandom_range(0, ca * cd * 9 - 1)));
        else if (n < 5) queue_item(goch_pkg::CMD_NONE, 8'($urandom), 10'($urandom));
      end
      for (int i = $urandom_range(0, 3); i > 0; i--)
        queue_item(goch_pkg::CMD_PUSH, 8'($urandom), 10'($urandom));
      for (int i = 0; i < ca * cd * 9 && i < 36; i++)
        queue_item(goch_pkg::CMD_READ, 8'($urandom), 10'(i));
      for (int i = $urandom_range(1, 3); i > 0; i--)
        queue_item(goch_pkg::CMD_READ, 8'($urandom), 10'($urandom));
      wait_drained();
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("sent %0d transactions over %0d size settings, checked %0d results",
             items_sent, phases, results_seen);
    $display("mismatches: %0d, outstanding: %0d", mismatches, expected_results.size());
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: gradient_orientation_cell_histogram_top.f
rtl/goch_pkg.sv
rtl/goch_fifo.sv
rtl/goch_back.sv
rtl/goch_front.sv
rtl/gradient_orientation_cell_histogram_top.sv
bench/tb.sv
